### hw/rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types, constants and the exp(-z) table for the cooling profile core.
// ----------------------------------------------------------------------------
package ctp_pkg;

    // exp(-z) table: EXP_TABLE_DEPTH+1 Q0.32 entries over z in [0, 32].
    // Depth is a power of two, 32 .. 4096.
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_LG          = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_ADDR_W      = EXP_LG + 1;
    localparam int EXP_BLOCK       = EXP_TABLE_DEPTH / 32;  // entries per unit of z

    // exp argument: Q5.32, anything at or above 32.0 is flagged as zero
    localparam int Z_W      = 37;
    // square of a gaussian argument below 6.0 needs 38 bits
    localparam int SQ_W     = 38;
    // top bit of the interpolation fraction within {z, 7'b0}
    localparam int FRAC_TOP = 43 - EXP_LG;

    localparam logic [63:0] ONE_Q32       = 64'h0000_0001_0000_0000;
    localparam logic [63:0] DGAUSS_CENTER = 64'h0000_0003_0000_0000;
    localparam logic [63:0] GAUSS_LIMIT   = 64'h0000_0006_0000_0000;
    localparam logic [32:0] EXP_ONE       = 33'h1_0000_0000;

    typedef enum logic [1:0] {
        CURVE_EXP    = 2'd0,
        CURVE_GAUSS  = 2'd1,
        CURVE_DGAUSS = 2'd2,
        CURVE_LINEAR = 2'd3
    } curve_mode_t;

    typedef enum logic [1:0] {
        REG_CURVE_MODE    = 2'd0,
        REG_TEMP_LOW      = 2'd1,
        REG_TEMP_HIGH     = 2'd2,
        REG_STEP_OVER_TAU = 2'd3
    } reg_index_t;

    typedef struct packed {
        curve_mode_t curve_mode;
        logic [31:0] temp_low;
        logic [31:0] temp_high;
        logic [31:0] step_over_tau;
    } cfg_t;

    // argument stage -> exp stage
    typedef struct packed {
        logic           zero;   // exp(-z) is zero (z >= 32 or gaussian out of range)
        logic [Z_W-1:0] z;
        logic [63:0]    x;      // scaled time, Q32.32
    } arg_t;

    // exp stage -> blend stage
    typedef struct packed {
        logic [32:0] e;         // exp value, Q0.32 up to 1.0
        logic [63:0] x;
    } expv_t;

    typedef logic [EXP_TABLE_DEPTH:0][32:0] exp_rom_t;

    // Q0.32 product, truncating; a, b <= 2^32
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        return (a >> 32) * b + (((a & 64'h0000_0000_FFFF_FFFF) * b) >> 32);
    endfunction

    // exp(-f), f in [0,1), 20-term series
    function automatic logic [63:0] exp_series(input logic [63:0] f);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = ONE_Q32;
        term = ONE_Q32;
        for (int k = 1; k <= 20; k++)
        begin
            term = mul_q32(term, f) / 64'(k);
            if ((k & 1) == 1)
            begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end
            else
            begin
                sum = sum + term;
                if (sum > ONE_Q32)
                begin
                    sum = ONE_Q32;
                end
            end
        end
        return sum;
    endfunction

    // entry i = series(frac) * e^-1 applied n times; an entry one unit of z
    // further on is the earlier entry times e^-1 once more
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] half;
        logic [63:0] e1;
        logic [63:0] v;
        rom  = '0;
        half = exp_series(64'h0000_0000_8000_0000);
        e1   = mul_q32(half, half);
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++)
        begin
            if (i < EXP_BLOCK)
            begin
                v = exp_series((64'(32 * i) << 32) / 64'(EXP_TABLE_DEPTH));
            end
            else
            begin
                v = mul_q32(64'(rom[i - EXP_BLOCK]), e1);
            end
            rom[i] = 33'(v);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### hw/rtl/ctp_arg.sv
// ----------------------------------------------------------------------------
// ctp_arg
// Scaled time and exp argument: four stages (scale, center, square, sum).
// ----------------------------------------------------------------------------
module ctp_arg
    import ctp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_steps,
    output logic        out_valid,
    input  logic        out_ready,
    output arg_t        out_arg
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic [63:0]    x1_reg, x1_next;
    logic [63:0]    x2_reg, x3_reg;
    logic [34:0]    a2_reg, a2_next;
    logic           big2_reg, big2_next, big3_reg;
    logic [63:0]    ll3_reg, ll3_next;
    logic [34:0]    hl3_reg, hl3_next;
    logic [5:0]     hh3_reg, hh3_next;
    logic [63:0]    a_full;
    logic [SQ_W-1:0] sq;
    arg_t           arg4_reg, arg4_next;

    // bubble-collapsing stage enables
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: x = steps * step_over_tau, Q32.32, cannot overflow
    assign x1_next = 64'(in_steps) * 64'(cfg.step_over_tau);

    // stage 2: gaussian argument, distance from 3.0 in double gaussian
    always_comb
    begin
        if (cfg.curve_mode == CURVE_DGAUSS)
        begin
            a_full = (x1_reg >= DGAUSS_CENTER) ? x1_reg - DGAUSS_CENTER
                                               : DGAUSS_CENTER - x1_reg;
        end
        else
        begin
            a_full = x1_reg;
        end
        big2_next = (a_full >= GAUSS_LIMIT);
        a2_next   = a_full[34:0];
    end

    // stage 3: partial squares, a = ah.al with ah below 6
    assign ll3_next = 64'(a2_reg[31:0]) * 64'(a2_reg[31:0]);
    assign hl3_next = 35'(a2_reg[34:32]) * 35'(a2_reg[31:0]);
    assign hh3_next = 6'(a2_reg[34:32]) * 6'(a2_reg[34:32]);

    // stage 4: sum the square, pick the exp argument
    always_comb
    begin
        sq = {hh3_reg, 32'd0} + SQ_W'({hl3_reg, 1'b0}) + SQ_W'(ll3_reg[63:32]);
        arg4_next.x = x3_reg;
        if (cfg.curve_mode == CURVE_EXP)
        begin
            arg4_next.zero = |x3_reg[63:Z_W];
            arg4_next.z    = x3_reg[Z_W-1:0];
        end
        else
        begin
            arg4_next.zero = big3_reg || (|sq[SQ_W-1:Z_W]);
            arg4_next.z    = sq[Z_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg <= x1_next;
        end
        if (en2)
        begin
            x2_reg   <= x1_reg;
            a2_reg   <= a2_next;
            big2_reg <= big2_next;
        end
        if (en3)
        begin
            x3_reg   <= x2_reg;
            big3_reg <= big2_reg;
            ll3_reg  <= ll3_next;
            hl3_reg  <= hl3_next;
            hh3_reg  <= hh3_next;
        end
        if (en4)
        begin
            arg4_reg <= arg4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_arg   = arg4_reg;

endmodule

### hw/rtl/ctp_exp.sv
// ----------------------------------------------------------------------------
// ctp_exp
// exp(-z) by table lookup and linear interpolation: three stages.
// ----------------------------------------------------------------------------
module ctp_exp
    import ctp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  arg_t  in_arg,
    output logic  out_valid,
    input  logic  out_ready,
    output expv_t out_exp
);

    logic v5_reg, v6_reg, v7_reg;
    logic en5, en6, en7;

    logic [EXP_ADDR_W-1:0] addr0, addr1;
    logic [Z_W+6:0]        z_sh;
    logic [32:0]           e0_5_reg, e0_5_next, e1_5_reg, e1_5_next;
    logic [31:0]           frac5_reg, frac5_next;
    logic                  zero5_reg, zero6_reg;
    logic [63:0]           x5_reg, x6_reg;
    logic [32:0]           diff;
    logic [64:0]           prod6_reg, prod6_next;
    logic [32:0]           e0_6_reg;
    logic                  keep6_reg, keep6_next;
    expv_t                 exp7_reg, exp7_next;

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign in_ready = en5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en5) v5_reg <= in_valid;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // stage 5: table index is the top bits of z, fraction the rest
    assign addr0      = {1'b0, in_arg.z[Z_W-1 -: EXP_LG]};
    assign addr1      = addr0 + EXP_ADDR_W'(1);
    assign z_sh       = {in_arg.z, 7'd0};
    assign frac5_next = z_sh[FRAC_TOP -: 32];
    assign e0_5_next  = EXP_ROM[addr0];
    assign e1_5_next  = EXP_ROM[addr1];

    // stage 6: (e0 - e1) * frac
    assign keep6_next = (e1_5_reg > e0_5_reg);
    assign diff       = e0_5_reg - e1_5_reg;
    assign prod6_next = 65'(diff) * 65'(frac5_reg);

    // stage 7: interpolated value
    always_comb
    begin
        exp7_next.x = x6_reg;
        if (zero6_reg)
        begin
            exp7_next.e = '0;
        end
        else if (keep6_reg)
        begin
            exp7_next.e = e0_6_reg;
        end
        else
        begin
            exp7_next.e = e0_6_reg - prod6_reg[64:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            e0_5_reg  <= e0_5_next;
            e1_5_reg  <= e1_5_next;
            frac5_reg <= frac5_next;
            zero5_reg <= in_arg.zero;
            x5_reg    <= in_arg.x;
        end
        if (en6)
        begin
            prod6_reg <= prod6_next;
            e0_6_reg  <= e0_5_reg;
            keep6_reg <= keep6_next;
            zero6_reg <= zero5_reg;
            x6_reg    <= x5_reg;
        end
        if (en7)
        begin
            exp7_reg <= exp7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_exp   = exp7_reg;

endmodule

### hw/rtl/ctp_blend.sv
// ----------------------------------------------------------------------------
// ctp_blend
// Mix temp_low/temp_high by the curve value, saturate the linear ramp; output register.
// ----------------------------------------------------------------------------
module ctp_blend
    import ctp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  expv_t       in_exp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_temp
);

    logic v8_reg, v9_reg;
    logic en8, en9;

    logic        inv8_next, inv8_reg;
    logic [31:0] span;
    logic [32:0] mult_b;
    logic [64:0] pa8_reg, pa8_next;
    logic [63:0] pb8_reg, pb8_next;
    logic        ge1_8_reg, ge1_8_next, le1_8_reg, le1_8_next;
    logic [32:0] pa_hi;
    logic [33:0] rise_sum;
    logic [31:0] res9_reg, res9_next;

    assign en9      = !v9_reg || out_ready;
    assign en8      = !v8_reg || en9;
    assign in_ready = en8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            if (en8) v8_reg <= in_valid;
            if (en9) v9_reg <= v8_reg;
        end
    end

    // stage 8: span times curve value (or times x for the linear ramp)
    assign inv8_next  = (cfg.temp_high < cfg.temp_low);
    assign span       = inv8_next ? cfg.temp_low - cfg.temp_high
                                  : cfg.temp_high - cfg.temp_low;
    assign mult_b     = (cfg.curve_mode == CURVE_LINEAR) ? {1'b0, in_exp.x[31:0]} : in_exp.e;
    assign pa8_next   = 65'(span) * 65'(mult_b);
    assign pb8_next   = 64'(span) * 64'(in_exp.x[63:32]);
    assign ge1_8_next = |in_exp.x[63:32];
    assign le1_8_next = (in_exp.x <= ONE_Q32);

    // stage 9: final add and saturation
    assign pa_hi    = pa8_reg[64:32];
    assign rise_sum = 34'(pb8_reg[31:0]) + 34'(pa_hi) + 34'(cfg.temp_high);

    always_comb
    begin
        case (cfg.curve_mode)
            CURVE_LINEAR:
            begin
                if (!inv8_reg)
                begin
                    res9_next = ge1_8_reg ? cfg.temp_low : cfg.temp_high - pa_hi[31:0];
                end
                else if (le1_8_reg)
                begin
                    res9_next = cfg.temp_low;
                end
                else if ((|pb8_reg[63:32]) || (|rise_sum[33:32]))
                begin
                    res9_next = 32'hFFFF_FFFF;
                end
                else
                begin
                    res9_next = rise_sum[31:0];
                end
            end
            default:
            begin
                res9_next = inv8_reg ? cfg.temp_low - pa_hi[31:0]
                                     : cfg.temp_low + pa_hi[31:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en8)
        begin
            inv8_reg  <= inv8_next;
            pa8_reg   <= pa8_next;
            pb8_reg   <= pb8_next;
            ge1_8_reg <= ge1_8_next;
            le1_8_reg <= le1_8_next;
        end
        if (en9)
        begin
            res9_reg <= res9_next;
        end
    end

    assign out_valid = v9_reg;
    assign out_temp  = res9_reg;

endmodule

### hw/rtl/cooling_temperature_profile_core.sv
// ----------------------------------------------------------------------------
// cooling_temperature_profile_core
// Temperature setpoint of an annealing schedule from an elapsed step count.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per elapsed step count; m_axis returns one
//   setpoint (unsigned Q16.16) per request, in order.
//   cfg_* writes curve_mode (0), temp_low (1), temp_high (2) and
//   step_over_tau (3); cfg_ready is always high. Write only while idle.
//   Pipeline: nine register stages (scale, center, square, sum, table read,
//   interpolation multiply, interpolation subtract, blend multiply, output).
//   Throughput is one request per cycle, set by the per-stage valid
//   bits: every stage takes a new request each cycle when downstream moves.
//   Reset clears all valid bits and the config registers (all zero).
//   When m_axis_tready is low the result holds in the output register;
//   earlier stages keep filling empty slots, and s_axis_tready drops only
//   once every stage holds a request.
// ----------------------------------------------------------------------------
module cooling_temperature_profile_core
    import ctp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] elapsed_steps
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] setpoint_temp
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    curve_mode_t curve_mode_reg;
    logic [31:0] temp_low_reg;
    logic [31:0] temp_high_reg;
    logic [31:0] step_over_tau_reg;
    cfg_t        cfg;

    logic  arg_valid, arg_ready;
    arg_t  arg_data;
    logic  exp_valid, exp_ready;
    expv_t exp_data;

    // config port: one write per cycle, no back-pressure
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg    <= CURVE_EXP;
            temp_low_reg      <= '0;
            temp_high_reg     <= '0;
            step_over_tau_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_CURVE_MODE:    curve_mode_reg    <= curve_mode_t'(cfg_data[1:0]);
                REG_TEMP_LOW:      temp_low_reg      <= cfg_data;
                REG_TEMP_HIGH:     temp_high_reg     <= cfg_data;
                REG_STEP_OVER_TAU: step_over_tau_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.curve_mode    = curve_mode_reg;
    assign cfg.temp_low      = temp_low_reg;
    assign cfg.temp_high     = temp_high_reg;
    assign cfg.step_over_tau = step_over_tau_reg;

    // stages 1-4: x = steps * tau, gaussian square
    ctp_arg u_arg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_steps  (s_axis_tdata),
        .out_valid (arg_valid),
        .out_ready (arg_ready),
        .out_arg   (arg_data)
    );

    // stages 5-7: exp(-z) lookup and interpolation
    ctp_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (arg_valid),
        .in_ready  (arg_ready),
        .in_arg    (arg_data),
        .out_valid (exp_valid),
        .out_ready (exp_ready),
        .out_exp   (exp_data)
    );

    // stages 8-9: blend, saturate, output register
    ctp_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (exp_valid),
        .in_ready  (exp_ready),
        .in_exp    (exp_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_temp  (m_axis_tdata)
    );

`ifndef SYNTH
    // with nothing waiting at the output every stage can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    // interpolated exp never exceeds 1.0
    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid |-> (exp_data.e <= EXP_ONE))
        else $error("exp value above 1.0");

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> u_arg.v1_reg)
        else $error("accepted request lost at stage 1");
`endif

endmodule
